[hdl/mdss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdss_pkg: motor drive stall supervisor shared types
// command and mode codes, transfer payloads and configuration bundle
// ----------------------------------------------------------------------------
package mdss_pkg;

    localparam int NUM_LANES  = 2;
    localparam int CUR_W      = 12;
    localparam int CNT_W      = 8;
    localparam int INRUSH_W   = 16;
    localparam int SPEED_W    = 16;
    localparam int DUTY_W     = 7;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [DUTY_W-1:0]  DUTY_MAX      = 7'd100;
    localparam logic [SPEED_W-1:0] SPEED_POS_MAX = 16'sd100;
    localparam logic [SPEED_W-1:0] SPEED_NEG_MAX = -16'sd100;

    localparam logic [CUR_W-1:0]    THRESHOLD_RST = 12'd3000;
    localparam logic [CNT_W-1:0]    LIMIT_RST     = 8'd10;
    localparam logic [INRUSH_W-1:0] INRUSH_RST    = 16'd50;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_START     = 2'd1,
        CMD_STOP      = 2'd2,
        CMD_SET_SPEED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_STOPPED  = 2'd0,
        MODE_STARTING = 2'd1,
        MODE_RUNNING  = 2'd2,
        MODE_FAULT    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        REG_THRESHOLD = 2'd0,
        REG_LIMIT     = 2'd1,
        REG_INRUSH    = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]                command;
        logic signed [SPEED_W-1:0] speed;
        logic [CUR_W-1:0]          left_current;
        logic [CUR_W-1:0]          right_current;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] forward_duty;
        logic [DUTY_W-1:0] reverse_duty;
        logic [1:0]        motor_mode;
    } out_item_t;

    typedef struct packed {
        logic [CUR_W-1:0]    stall_threshold;
        logic [CNT_W-1:0]    stall_limit;
        logic [INRUSH_W-1:0] inrush_ticks;
    } cfg_t;

endpackage

[hdl/mdss_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdss_lane: per-motor stall counter
// counts consecutive over-threshold samples and flags when the limit is passed
// ----------------------------------------------------------------------------
module mdss_lane
    import mdss_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [CUR_W-1:0] sample,
    input  cfg_t             cfg,
    output logic             fault
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb begin
        if (sample > cfg.stall_threshold) begin
            // saturating increment
            count_next = (&count_reg) ? count_reg : count_reg + 1'b1;
        end else begin
            count_next = '0;
        end
    end

    assign fault = (count_next > cfg.stall_limit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (en) begin
            count_reg <= count_next;
        end
    end

endmodule

[hdl/mdss_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdss_regs: configuration register file
// apb-style write and read of threshold, limit and inrush time
// ----------------------------------------------------------------------------
module mdss_regs
    import mdss_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stall_threshold <= THRESHOLD_RST;
            cfg_reg.stall_limit     <= LIMIT_RST;
            cfg_reg.inrush_ticks    <= INRUSH_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_THRESHOLD: cfg_reg.stall_threshold <= pwdata[CUR_W-1:0];
                REG_LIMIT:     cfg_reg.stall_limit     <= pwdata[CNT_W-1:0];
                REG_INRUSH:    cfg_reg.inrush_ticks    <= pwdata[INRUSH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_THRESHOLD: prdata = {{(PDATA_W-CUR_W){1'b0}}, cfg_reg.stall_threshold};
            REG_LIMIT:     prdata = {{(PDATA_W-CNT_W){1'b0}}, cfg_reg.stall_limit};
            REG_INRUSH:    prdata = {{(PDATA_W-INRUSH_W){1'b0}}, cfg_reg.inrush_ticks};
            default:       prdata = '0;
        endcase
    end

endmodule

[hdl/motor_drive_stall_supervisor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_drive_stall_supervisor: dc motor bridge supervisor with stall watch
// each result is registered in the output register, or parked in the skid entry, before it drives m_valid
// throughput: one command per cycle while the skid entry is free; a two-entry output buffer keeps s_ready
// high while a single result waits for m_ready
// reset: synchronous active-low aresetn, mode stopped, duties and counts zero
// ----------------------------------------------------------------------------
module motor_drive_stall_supervisor
    import mdss_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // command channel
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // supervisor state
    mode_t               mode_reg,    mode_next;
    logic [INRUSH_W-1:0] inrush_reg,  inrush_next;
    logic [DUTY_W-1:0]   fwd_reg,     fwd_next;
    logic [DUTY_W-1:0]   rev_reg,     rev_next;

    // output buffer: main register plus skid entry
    out_item_t out_reg;
    logic      out_valid_reg;
    out_item_t skid_reg;
    logic      skid_valid_reg;

    cfg_t             cfg;
    cmd_t             cmd;
    logic             in_xfer;
    logic             lane_en;
    logic [NUM_LANES-1:0]           lane_fault;
    logic [NUM_LANES-1:0][CUR_W-1:0] lane_sample;
    logic                           any_fault;
    out_item_t                      result;
    logic [INRUSH_W-1:0]            inrush_inc;
    logic [SPEED_W-1:0]             speed_neg;

    assign pready = 1'b1;

    mdss_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign cmd     = cmd_t'(s_data.command);
    assign in_xfer = s_valid && s_ready;

    // lanes only advance on a tick while running
    assign lane_en = in_xfer && (cmd == CMD_TICK) && (mode_reg == MODE_RUNNING);

    assign lane_sample[0] = s_data.left_current;
    assign lane_sample[1] = s_data.right_current;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        mdss_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (lane_en),
            .sample  (lane_sample[g]),
            .cfg     (cfg),
            .fault   (lane_fault[g])
        );
    end

    // merge: a fault on any lane trips the bridge
    assign any_fault = |lane_fault;

    // saturating inrush count
    assign inrush_inc = (&inrush_reg) ? inrush_reg : inrush_reg + 1'b1;
    assign speed_neg  = '0 - s_data.speed;

    always_comb begin
        mode_next   = mode_reg;
        inrush_next = inrush_reg;
        fwd_next    = fwd_reg;
        rev_next    = rev_reg;
        unique case (cmd)
            CMD_TICK: begin
                if (mode_reg == MODE_STARTING) begin
                    inrush_next = inrush_inc;
                    if (inrush_inc >= cfg.inrush_ticks) begin
                        mode_next = MODE_RUNNING;
                    end
                end else if (mode_reg == MODE_RUNNING && any_fault) begin
                    fwd_next  = '0;
                    rev_next  = '0;
                    mode_next = MODE_FAULT;
                end
            end
            CMD_START: begin
                inrush_next = '0;
                mode_next   = MODE_STARTING;
            end
            CMD_STOP: begin
                fwd_next  = '0;
                rev_next  = '0;
                mode_next = MODE_STOPPED;
            end
            CMD_SET_SPEED: begin
                // clamp to plus or minus full duty, sign picks the bridge side
                if ($signed(s_data.speed) > $signed(SPEED_POS_MAX)) begin
                    fwd_next = DUTY_MAX;
                    rev_next = '0;
                end else if ($signed(s_data.speed) < $signed(SPEED_NEG_MAX)) begin
                    fwd_next = '0;
                    rev_next = DUTY_MAX;
                end else if ($signed(s_data.speed) > 0) begin
                    fwd_next = s_data.speed[DUTY_W-1:0];
                    rev_next = '0;
                end else if ($signed(s_data.speed) < 0) begin
                    fwd_next = '0;
                    rev_next = speed_neg[DUTY_W-1:0];
                end else begin
                    fwd_next = '0;
                    rev_next = '0;
                end
            end
            default: ;
        endcase
    end

    assign result.forward_duty = fwd_next;
    assign result.reverse_duty = rev_next;
    assign result.motor_mode   = mode_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_STOPPED;
            inrush_reg <= '0;
            fwd_reg    <= '0;
            rev_reg    <= '0;
        end else if (in_xfer) begin
            mode_reg   <= mode_next;
            inrush_reg <= inrush_next;
            fwd_reg    <= fwd_next;
            rev_reg    <= rev_next;
        end
    end

    // input side stalls only when the skid entry is occupied
    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            // output register free or draining this cycle
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_xfer;
            end
        end else if (in_xfer) begin
            // result waiting downstream, park the new one
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (in_xfer) begin
                out_reg <= result;
            end
        end else if (in_xfer) begin
            skid_reg <= result;
        end
    end

endmodule

[dv/motor_drive_stall_supervisor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motor_drive_stall_supervisor_tb: self-checking bench for the stall supervisor
// a scripted run of commands and register writes comes first, then randomised
// motor sessions under several register settings and idle patterns; every
// result transfer is checked against a pinned value or an in-bench model of the supervisor
// ----------------------------------------------------------------------------
module motor_drive_stall_supervisor_tb;
    import mdss_pkg::*;

    localparam int SPEED_CLAMP = int'(DUTY_MAX);
    localparam int CUR_TOP     = (1 << CUR_W) - 1;
    localparam int NUM_PHASES  = 9;
    localparam int DRAIN_LIMIT = 20000;
    // quiet tail run once every owed result is back
    localparam int TAIL_CYCLES = 8;
    localparam int LONG_HOLD   = 60;

    // ------------------------------------------------------------------------
    // dut signals
    // ------------------------------------------------------------------------
    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_item_t           s_data;
    logic               m_valid;
    logic               m_ready;
    out_item_t          m_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    motor_drive_stall_supervisor dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // scripted stimulus: either a register write or a command, the latter with
    // an optional hand-written expectation
    // ------------------------------------------------------------------------
    typedef struct {
        bit                 is_write;
        reg_idx_t           reg_sel;
        logic [PDATA_W-1:0] reg_val;
        in_item_t           cmd;
        bit                 pinned;
        out_item_t          want;
    } script_row_t;

    script_row_t script[$];

    // ------------------------------------------------------------------------
    // supervisor model state and its copy of the registers
    // ------------------------------------------------------------------------
    mode_t               pred_mode;
    logic [INRUSH_W-1:0] pred_inrush;
    logic [CNT_W-1:0]    pred_stall [NUM_LANES];
    logic [DUTY_W-1:0]   pred_fwd;
    logic [DUTY_W-1:0]   pred_rev;
    logic [CUR_W-1:0]    cfg_threshold;
    logic [CNT_W-1:0]    cfg_limit;
    logic [INRUSH_W-1:0] cfg_inrush;

    // results still owed by the dut, oldest first
    out_item_t pending_results[$];
    out_item_t oldest;

    // idle and stall pattern for the current phase, in percent
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    // long receiver hold-off, picked up and counted down by the receiver
    int hold_request    = 0;

    int items_sent      = 0;
    int results_seen    = 0;
    int running_results = 0;
    int fault_results   = 0;
    int reg_writes      = 0;
    int mismatches      = 0;

    // ------------------------------------------------------------------------
    // model: one command in, the bridge state after it out
    // ------------------------------------------------------------------------

    // consecutive over-threshold count for one motor, true once past the limit
    function automatic bit lane_over_limit(int lane, logic [CUR_W-1:0] sample);
        if (sample > cfg_threshold) begin
            if (pred_stall[lane] != '1)
                pred_stall[lane] = pred_stall[lane] + 1'b1;
            return pred_stall[lane] > cfg_limit;
        end
        pred_stall[lane] = '0;
        return 1'b0;
    endfunction

    function automatic out_item_t apply_command(in_item_t c);
        int        sp;
        bit        trip_l;
        bit        trip_r;
        out_item_t r;
        case (c.command)
            CMD_TICK: begin
                if (pred_mode == MODE_STARTING) begin
                    if (pred_inrush != '1)
                        pred_inrush = pred_inrush + 1'b1;
                    if (pred_inrush >= cfg_inrush)
                        pred_mode = MODE_RUNNING;
                end else if (pred_mode == MODE_RUNNING) begin
                    // both lanes are updated even when the left one trips
                    trip_l = lane_over_limit(0, c.left_current);
                    trip_r = lane_over_limit(1, c.right_current);
                    if (trip_l || trip_r) begin
                        pred_fwd  = '0;
                        pred_rev  = '0;
                        pred_mode = MODE_FAULT;
                    end
                end
            end
            CMD_START: begin
                pred_inrush = '0;
                pred_mode   = MODE_STARTING;
            end
            CMD_STOP: begin
                pred_fwd  = '0;
                pred_rev  = '0;
                pred_mode = MODE_STOPPED;
            end
            default: begin
                sp = int'($signed(c.speed));
                if (sp > SPEED_CLAMP)
                    sp = SPEED_CLAMP;
                if (sp < -SPEED_CLAMP)
                    sp = -SPEED_CLAMP;
                if (sp > 0) begin
                    pred_fwd = DUTY_W'(sp);
                    pred_rev = '0;
                end else if (sp < 0) begin
                    pred_fwd = '0;
                    pred_rev = DUTY_W'(-sp);
                end else begin
                    pred_fwd = '0;
                    pred_rev = '0;
                end
            end
        endcase
        r.forward_duty = pred_fwd;
        r.reverse_duty = pred_rev;
        r.motor_mode   = pred_mode;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic out_item_t bridge_state(int fwd, int rev, mode_t m);
        out_item_t r;
        r.forward_duty = DUTY_W'(fwd);
        r.reverse_duty = DUTY_W'(rev);
        r.motor_mode   = m;
        return r;
    endfunction

    // every field random, so unused fields still toggle all their bits
    function automatic in_item_t random_item(cmd_t op);
        in_item_t c;
        c.command       = op;
        c.speed         = SPEED_W'($urandom);
        c.left_current  = CUR_W'($urandom);
        c.right_current = CUR_W'($urandom);
        return c;
    endfunction

    // a sample above (or the top value, if none is above) or at/below the current threshold
    function automatic logic [CUR_W-1:0] pick_current(bit hot);
        if (hot) begin
            if (cfg_threshold == '1)
                return '1;
            return CUR_W'($urandom_range(CUR_TOP, int'(cfg_threshold) + 1));
        end
        return CUR_W'($urandom_range(int'(cfg_threshold), 0));
    endfunction

    task automatic add_cmd(cmd_t op, int speed, int left, int right, bit pin,
                           out_item_t want);
        script_row_t row;
        row.is_write            = 1'b0;
        row.reg_sel             = REG_NONE;
        row.reg_val             = '0;
        row.cmd.command         = op;
        row.cmd.speed           = SPEED_W'(speed);
        row.cmd.left_current    = CUR_W'(left);
        row.cmd.right_current   = CUR_W'(right);
        row.pinned              = pin;
        row.want                = want;
        script.push_back(row);
    endtask

    task automatic add_cfg(reg_idx_t idx, int value);
        script_row_t row;
        row.is_write = 1'b1;
        row.reg_sel  = idx;
        row.reg_val  = PDATA_W'(value);
        row.cmd      = '0;
        row.pinned   = 1'b0;
        row.want     = '0;
        script.push_back(row);
    endtask

    // ------------------------------------------------------------------------
    // command channel driver: entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_command(in_item_t c, bit pinned, out_item_t typed);
        out_item_t predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        // hold the command until the transfer completes
        do @(posedge aclk); while (!s_ready);
        predicted = apply_command(c);
        pending_results.push_back(pinned ? typed : predicted);
        items_sent++;
        @(negedge aclk);
    endtask

    // sender goes quiet until every owed result is back or the drain limit runs out, then a short tail
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    // apb write, only ever issued with the supervisor idle
    task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // the registers keep only their own width; the spare index is ignored
        case (idx)
            REG_THRESHOLD: cfg_threshold = value[CUR_W-1:0];
            REG_LIMIT:     cfg_limit     = value[CNT_W-1:0];
            REG_INRUSH:    cfg_inrush    = value[INRUSH_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // one motor session: speed, start, enough ticks to get through an inrush of up to 60 ticks
    // and some way into running, with stray commands mixed in
    task automatic run_session();
        in_item_t c;
        int       ticks;
        int       hot_pct;
        int       roll;
        c = random_item(CMD_SET_SPEED);
        if ($urandom_range(1) == 1)
            c.speed = SPEED_W'(int'($urandom_range(300)) - 150);
        send_command(c, 1'b0, '0);
        send_command(random_item(CMD_START), 1'b0, '0);
        if (cfg_inrush > 60)
            ticks = int'($urandom_range(60, 20));
        else
            ticks = int'(cfg_inrush) + int'($urandom_range(40, 5));
        case ($urandom_range(2))
            0:       hot_pct = 10;
            1:       hot_pct = 60;
            default: hot_pct = 95;
        endcase
        repeat (ticks) begin
            roll = int'($urandom_range(99));
            if (roll < 3) begin
                c = random_item(CMD_SET_SPEED);
            end else if (roll < 5) begin
                c = random_item(CMD_STOP);
            end else if (roll < 7) begin
                c = random_item(CMD_START);
            end else begin
                c = random_item(CMD_TICK);
                // a few ticks keep fully random samples
                if (roll < 95) begin
                    c.left_current  = pick_current($urandom_range(99) < hot_pct);
                    c.right_current = pick_current($urandom_range(99) < hot_pct);
                end
            end
            send_command(c, 1'b0, '0);
        end
    endtask

    // sustained overcurrent on both motors, long enough to saturate the counts
    task automatic long_stall_run();
        in_item_t c;
        send_command(random_item(CMD_START), 1'b0, '0);
        repeat (int'(cfg_inrush) + 270) begin
            c = random_item(CMD_TICK);
            c.left_current  = pick_current(1'b1);
            c.right_current = pick_current(1'b1);
            send_command(c, 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // result channel: random back-pressure plus the occasional long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready    = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // each result transfer is matched against the oldest owed result
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_data.motor_mode == MODE_RUNNING)
                running_results++;
            if (m_data.motor_mode == MODE_FAULT)
                fault_results++;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing outstanding: %h", m_data);
                mismatches++;
            end else begin
                oldest = pending_results.pop_front();
                if (m_data.forward_duty !== oldest.forward_duty) begin
                    $error("forward_duty mismatch: expected %0d, got %0d",
                           oldest.forward_duty, m_data.forward_duty);
                    mismatches++;
                end
                if (m_data.reverse_duty !== oldest.reverse_duty) begin
                    $error("reverse_duty mismatch: expected %0d, got %0d",
                           oldest.reverse_duty, m_data.reverse_duty);
                    mismatches++;
                end
                if (m_data.motor_mode !== oldest.motor_mode) begin
                    $error("motor_mode mismatch: expected %0d, got %0d",
                           oldest.motor_mode, m_data.motor_mode);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int                 p;
        int                 start_count;
        int                 target;
        logic [PDATA_W-1:0] thr;
        logic [PDATA_W-1:0] lim;
        logic [PDATA_W-1:0] inr;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;

        // model starts from the reset state
        pred_mode     = MODE_STOPPED;
        pred_inrush   = '0;
        pred_stall[0] = '0;
        pred_stall[1] = '0;
        pred_fwd      = '0;
        pred_rev      = '0;
        cfg_threshold = THRESHOLD_RST;
        cfg_limit     = LIMIT_RST;
        cfg_inrush    = INRUSH_RST;

        // ---- scripted part ----
        // reset settings: ticks are ignored while stopped, speed clamps both ways
        add_cmd(CMD_TICK, 0, 4095, 4095, 1, bridge_state(0, 0, MODE_STOPPED));
        add_cmd(CMD_SET_SPEED, 32767, 0, 0, 1, bridge_state(100, 0, MODE_STOPPED));
        add_cmd(CMD_SET_SPEED, -32768, 0, 0, 1, bridge_state(0, 100, MODE_STOPPED));
        add_cmd(CMD_SET_SPEED, 0, 0, 0, 1, bridge_state(0, 0, MODE_STOPPED));
        add_cmd(CMD_SET_SPEED, 1, 0, 0, 1, bridge_state(1, 0, MODE_STOPPED));
        add_cmd(CMD_SET_SPEED, -1, 0, 0, 1, bridge_state(0, 1, MODE_STOPPED));
        add_cmd(CMD_SET_SPEED, 101, 0, 0, 1, bridge_state(100, 0, MODE_STOPPED));
        add_cmd(CMD_SET_SPEED, -101, 0, 0, 1, bridge_state(0, 100, MODE_STOPPED));
        add_cmd(CMD_STOP, 0, 0, 0, 1, bridge_state(0, 0, MODE_STOPPED));
        // no inrush, fault on the first hot tick; the spare index must not alias
        add_cfg(REG_INRUSH, 0);
        add_cfg(REG_LIMIT, 0);
        add_cfg(REG_THRESHOLD, 4094);
        add_cfg(REG_NONE, 0);
        add_cmd(CMD_SET_SPEED, 50, 0, 0, 0, '0);
        add_cmd(CMD_START, 0, 0, 0, 1, bridge_state(50, 0, MODE_STARTING));
        add_cmd(CMD_TICK, 0, 0, 0, 1, bridge_state(50, 0, MODE_RUNNING));
        // a sample equal to the threshold does not count
        add_cmd(CMD_TICK, 0, 4094, 4094, 0, '0);
        add_cmd(CMD_TICK, 0, 4095, 0, 1, bridge_state(0, 0, MODE_FAULT));
        add_cmd(CMD_TICK, 0, 4095, 4095, 0, '0);
        add_cmd(CMD_SET_SPEED, -7, 0, 0, 0, '0);
        // restart out of fault keeps duties and counts
        add_cmd(CMD_START, 0, 0, 0, 0, '0);
        add_cmd(CMD_TICK, 0, 0, 4095, 0, '0);
        add_cmd(CMD_TICK, 0, 0, 4095, 0, '0);
        add_cfg(REG_LIMIT, 255);
        add_cfg(REG_INRUSH, 2);
        add_cmd(CMD_START, 0, 0, 0, 0, '0);
        add_cmd(CMD_TICK, 0, 4095, 4095, 0, '0);
        add_cmd(CMD_TICK, 0, 4095, 4095, 0, '0);
        add_cmd(CMD_TICK, 0, 4095, 4095, 0, '0);
        add_cmd(CMD_STOP, 0, 0, 0, 1, bridge_state(0, 0, MODE_STOPPED));

        // synchronous reset, released on a falling edge
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        foreach (script[i]) begin
            if (script[i].is_write)
                write_reg(script[i].reg_sel, script[i].reg_val);
            else
                send_command(script[i].cmd, script[i].pinned, script[i].want);
        end

        // ---- randomised phases ----
        for (p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin thr = 3000; lim = 10;  inr = 50;    end
                1: begin thr = 0;    lim = 0;   inr = 0;     end
                2: begin thr = 4095; lim = 255; inr = 65535; end
                3: begin thr = 2048; lim = 3;   inr = 5;     end
                4: begin thr = 100;  lim = 255; inr = 1;     end
                5: begin thr = 1500; lim = 20;  inr = 10;    end
                6: begin thr = 3500; lim = 1;   inr = 2;     end
                default: begin
                    thr = $urandom_range(CUR_TOP);
                    lim = $urandom_range(30);
                    inr = $urandom_range(40);
                end
            endcase
            // junk above each register's width must be dropped
            write_reg(REG_THRESHOLD, ($urandom << CUR_W) | thr);
            write_reg(REG_LIMIT, ($urandom << CNT_W) | lim);
            write_reg(REG_INRUSH, ($urandom << INRUSH_W) | inr);
            if (p % 2 == 1)
                write_reg(REG_NONE, $urandom);

            case (p % 4)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 77; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin sender_idle_pct = 7;  recv_stall_pct = 7;  end
            endcase

            // receiver blocks for a while as the sender keeps pushing, so the
            // output buffer fills and the command channel backs up
            if (p == 0)
                hold_request = LONG_HOLD;

            start_count = items_sent;
            target      = (p == 2) ? 60 : 140;
            if (p == 4)
                long_stall_run();
            while (items_sent - start_count < target) begin
                if ($urandom_range(99) < 80)
                    run_session();
                else
                    send_command(random_item(cmd_t'($urandom_range(3))), 1'b0, '0);
            end
        end

        // ---- wind down ----
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            mismatches++;
        end

        $display("run covered %0d commands and %0d register writes over %0d phases",
                 items_sent, reg_writes, NUM_PHASES);
        $display("%0d results checked: %0d while running, %0d reporting a fault",
                 results_seen, running_results, fault_results);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
